>>> sv/lcg_xor_stream_cipher_unit_assert.svh
// assertion macros used by the cipher unit checker
`ifndef LCG_XOR_STREAM_CIPHER_UNIT_ASSERT_SVH
`define LCG_XOR_STREAM_CIPHER_UNIT_ASSERT_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define LXSC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lxsc assertion failed");

// next-cycle implication
`define LXSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lxsc assertion failed");

`endif

>>> sv/lxsc_pkg.sv
// ============================================================================
// lxsc_pkg
// shared types, constants and helpers of the lcg keystream xor cipher unit
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package lxsc_pkg;

   localparam int WORD_W     = 32;
   localparam int BYTE_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int KEY_SHIFT  = 20;
   localparam int STEP_CNT_W = $clog2(WORD_W);

   localparam logic [WORD_W-1:0] DEFAULT_SEED       = WORD_W'(1);
   localparam logic [WORD_W-1:0] DEFAULT_MODULUS    = WORD_W'(1) << 19;
   localparam logic [WORD_W-1:0] DEFAULT_MULTIPLIER = WORD_W'(2) << 20;
   localparam logic [WORD_W-1:0] DEFAULT_INCREMENT  = WORD_W'(3) << 21;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEED       = 2'd0,
      CSR_MODULUS    = 2'd1,
      CSR_MULTIPLIER = 2'd2,
      CSR_INCREMENT  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_MULTIPLY,
      ST_EMIT
   } state_type;

   // zero in a register selects its default
   function automatic logic [WORD_W-1:0] pick(input logic [WORD_W-1:0] value,
                                              input logic [WORD_W-1:0] fallback);
      pick = (value != '0) ? value : fallback;
   endfunction

endpackage

`default_nettype wire

>>> sv/lcg_xor_stream_cipher_unit.sv
// ============================================================================
// lcg_xor_stream_cipher_unit
// byte stream cipher: xor with a keystream from a configurable lcg
// ============================================================================
// usage
//   req_*  : one message byte per request, tlast marks the final byte
//   rsp_*  : one transformed byte per request, tlast copied from the request
//   csr_*  : register writes (seed, modulus, multiplier, increment); always
//            ready, to be used only while no request is in flight
// each request advances the keystream word as
//   word = multiplier * (word mod modulus) + increment  (mod 2^32)
// and the byte is xored with word[27:20]; zero registers select defaults
// each request runs 32 steps of the remainder unit, then a hand-over, a
//   multiply and an add/emit
// one request at a time; req_tready is low while busy
// a stalled response sits in the output register; the next request is still
//   accepted and computed, and waits before emit until the register frees
// reset: registers return to defaults, keystream word reloads the seed, no
//   response pending; a seed write or a final byte also reloads the word
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lcg_xor_stream_cipher_unit
   import lxsc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request: data_byte[7:0]
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [BYTE_W-1:0]    req_tdata,
   input  wire logic                 req_tlast,
   // response: out_byte[7:0]
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [BYTE_W-1:0]         rsp_tdata,
   output logic                      rsp_tlast,
   // register write
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]    csr_data
);

   state_type         state_ff, state_in;
   logic [WORD_W-1:0] seed_ff, modulus_ff, multiplier_ff, increment_ff;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [WORD_W-1:0] prod_ff, prod_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              last_ff, last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              rem_start;
   logic              rem_done;
   logic [WORD_W-1:0] rem_value;
   logic [WORD_W-1:0] key_word;
   logic              csr_write;

   // effective register values
   logic [WORD_W-1:0] seed_eff, mod_eff, mul_eff, inc_eff;
   assign seed_eff = pick(seed_ff, DEFAULT_SEED);
   assign mod_eff  = pick(modulus_ff, DEFAULT_MODULUS);
   assign mul_eff  = pick(multiplier_ff, DEFAULT_MULTIPLIER);
   assign inc_eff  = pick(increment_ff, DEFAULT_INCREMENT);

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   lxsc_remainder u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (word_ff),
      .divisor   (mod_eff),
      .done      (rem_done),
      .remainder (rem_value)
   );

   // new keystream word from the registered low product
   assign key_word = prod_ff + inc_eff;

   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      rem_start    = 1'b0;
      word_in      = word_ff;
      prod_in      = prod_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      // response taken frees the output register
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               byte_in   = req_tdata;
               last_in   = req_tlast;
               rem_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (rem_done) begin
               state_in = ST_MULTIPLY;
            end
         end
         ST_MULTIPLY: begin
            // low 32 bits of the product are all that survive the wrap
            prod_in  = mul_eff * rem_value;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = byte_ff ^ key_word[KEY_SHIFT +: BYTE_W];
               rsp_last_in  = last_ff;
               // end of message restarts the keystream
               word_in      = last_ff ? seed_eff : key_word;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // seed write reloads the running word at once
      if (csr_write && (csr_index == CSR_SEED)) begin
         word_in = pick(csr_data, DEFAULT_SEED);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         word_ff       <= DEFAULT_SEED;
         seed_ff       <= DEFAULT_SEED;
         modulus_ff    <= DEFAULT_MODULUS;
         multiplier_ff <= DEFAULT_MULTIPLIER;
         increment_ff  <= DEFAULT_INCREMENT;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         word_ff      <= word_in;
         if (csr_write) begin
            case (csr_index)
               CSR_SEED:       seed_ff       <= csr_data;
               CSR_MODULUS:    modulus_ff    <= csr_data;
               CSR_MULTIPLIER: multiplier_ff <= csr_data;
               CSR_INCREMENT:  increment_ff  <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      byte_ff     <= byte_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

>>> sv/lxsc_remainder.sv
// ============================================================================
// lxsc_remainder
// iterative remainder unit, one restoring shift-compare-subtract step a cycle
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module lxsc_remainder
   import lxsc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [WORD_W-1:0] dividend,
   input  wire logic [WORD_W-1:0] divisor,
   output logic                   done,
   output logic [WORD_W-1:0]      remainder
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [WORD_W-1:0]     dvd_ff, dvd_in;
   logic [WORD_W-1:0]     div_ff, div_in;
   logic [WORD_W-1:0]     rem_ff, rem_in;
   logic [WORD_W:0]       shifted;
   logic                  fits;

   // the shared compare/subtract
   assign shifted = {rem_ff, dvd_ff[WORD_W-1]};
   assign fits    = shifted >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[WORD_W-2:0], 1'b0};
         rem_in = fits ? WORD_W'(shifted - {1'b0, div_ff}) : shifted[WORD_W-1:0];
         cnt_in = cnt_ff + STEP_CNT_W'(1);
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

>>> sv/lxsc_checker.sv
// ============================================================================
// lxsc_checker
// port-level assertions for the cipher unit, bound to the top level
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "lcg_xor_stream_cipher_unit_assert.svh"

module lxsc_checker
   import lxsc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   input  wire logic              req_tready,
   input  wire logic              rsp_tvalid,
   input  wire logic              rsp_tready,
   input  wire logic [BYTE_W-1:0] rsp_tdata,
   input  wire logic              rsp_tlast
);

   // one request at a time: busy right after an accept
   `LXSC_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)

   // a new response comes out as the unit goes back to taking requests
   `LXSC_ASSERT_NOW(a_ready_with_rsp, clock, reset, $rose(rsp_tvalid), req_tready)

   // stalled response stays offered
   `LXSC_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)

   // stalled response keeps its payload
   `LXSC_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tlast))

endmodule

bind lcg_xor_stream_cipher_unit lxsc_checker u_lxsc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
